// ===== rtl/core/dcgz_pkg.sv =====
// Shared types, register indexes and arithmetic constants of the DC-blocked Goertzel detector.
package dcgz_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COEF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 2'd3;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 16;
	localparam int BLOCK_LEN_W = 11;
	localparam int ENERGY_W = 63;
	localparam int DC_W = 18;

	localparam logic signed [COEF_W-1:0] CENTER_COEF_RESET = 16'sd20628;
	localparam logic signed [COEF_W-1:0] LOW_COEF_RESET = 16'sd24578;
	localparam logic signed [COEF_W-1:0] HIGH_COEF_RESET = 16'sd16076;
	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 11'd48;
	localparam int MIN_BLOCK = 8;

	localparam int DC_POLE = 32604;
	localparam int DC_SHIFT = 15;
	localparam int COEF_SHIFT = 14;
	localparam int SQ_SHIFT = 14;
	localparam int ENERGY_SHIFT = 30;

	localparam int CHUNK_W = 24;
	localparam int CHUNK_IDX_W = 2;
	localparam int SHIFT_IDX_W = 3;
	localparam int SHAMT_W = 7;

	localparam int NUM_BINS = 3;
	localparam int BIN_W = 2;
	localparam logic [BIN_W-1:0] BIN_CENTER = 2'd0;
	localparam logic [BIN_W-1:0] BIN_LOW = 2'd1;
	localparam logic [BIN_W-1:0] BIN_HIGH = 2'd2;

	typedef enum logic [2:0] {
		A_POLE,
		A_COEF,
		A_S1,
		A_S2,
		A_P
	} a_sel_t;

	typedef enum logic [1:0] {
		B_YP,
		B_S1,
		B_S2
	} b_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TAKE,
		OP_DC_FIN,
		OP_REC_FIN,
		OP_P_LOAD,
		OP_E_FIN
	} op_t;

	typedef struct packed {
		logic mul;
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic [CHUNK_IDX_W-1:0] a_chunk;
		logic [CHUNK_IDX_W-1:0] b_chunk;
		logic [SHIFT_IDX_W-1:0] shift;
		logic plus14;
		logic sub;
		op_t op;
		logic [BIN_W-1:0] bin;
		logic clear_bins;
	} dp_cmd_t;

	typedef struct packed {
		logic acc_pending;
	} dp_status_t;

endpackage

// ===== rtl/core/dc_blocked_goertzel_tone_detector.sv =====
// Top level of the DC-blocked three-bin Goertzel tone detector.
// Each accepted sample runs through a one-pole DC blocker and then the center, low and
// high Goertzel recurrences; after block_length samples (clamped to 8..MAX_BLOCK) one
// request carries the three bin energies and the recurrences restart from zero. A sample
// keeps the input stalled until its products are done: all products go through one shared
// 25x25 multiplier, seven partial products per sample at the default width, each followed
// by a registered accumulate. At a block end the energies are computed on the same
// multiplier, and the energy pass does not start while the previous result request is
// still waiting to be taken. Samples of the next block are accepted while a result waits.
module dc_blocked_goertzel_tone_detector #(
	parameter int MAX_BLOCK = 1024,
	parameter int RECURRENCE_WIDTH = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [dcgz_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dcgz_pkg::ENERGY_W-1:0]         center_energy,
	output logic [dcgz_pkg::ENERGY_W-1:0]         low_energy,
	output logic [dcgz_pkg::ENERGY_W-1:0]         high_energy,
	input  logic                                  cfg_write,
	input  logic [dcgz_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dcgz_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import dcgz_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dcgz_ctrl #(
		.MAX_BLOCK(MAX_BLOCK),
		.RECURRENCE_WIDTH(RECURRENCE_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.status(status)
	);

	dcgz_datapath #(
		.RECURRENCE_WIDTH(RECURRENCE_WIDTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample),
		.center_energy(center_energy),
		.low_energy(low_energy),
		.high_energy(high_energy)
	);

endmodule

// ===== rtl/core/dcgz_datapath.sv =====
// Datapath: coefficients, DC blocker and recurrence state, shared multiplier and accumulator.
module dcgz_datapath #(
	parameter int RECURRENCE_WIDTH = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dcgz_pkg::dp_cmd_t                     cmd,
	output dcgz_pkg::dp_status_t                  status,
	input  logic                                  cfg_write,
	input  logic [dcgz_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dcgz_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [dcgz_pkg::SAMPLE_W-1:0]  sample,
	output logic [dcgz_pkg::ENERGY_W-1:0]         center_energy,
	output logic [dcgz_pkg::ENERGY_W-1:0]         low_energy,
	output logic [dcgz_pkg::ENERGY_W-1:0]         high_energy
);
	import dcgz_pkg::*;

	localparam int RW = RECURRENCE_WIDTH;
	localparam int PW = RW + COEF_W;
	localparam int NCS = (RW + CHUNK_W - 1) / CHUNK_W;
	localparam int NCP = (PW + CHUNK_W - 1) / CHUNK_W;
	localparam int PX_W = NCP * CHUNK_W;
	localparam int ACC_W = 2 * RW + 16;
	localparam int EXT_W = ACC_W + 64;
	localparam int DC_SUM_W = DC_W + 3;
	localparam int REC_SUM_W = RW + 4;
	localparam int OP_W = CHUNK_W + 1;
	localparam int PROD_W = 2 * OP_W;
	localparam logic [CHUNK_IDX_W-1:0] S_TOP = CHUNK_IDX_W'(NCS - 1);
	localparam logic [CHUNK_IDX_W-1:0] P_TOP = CHUNK_IDX_W'(NCP - 1);

	logic signed [COEF_W-1:0]   center_coef_q, low_coef_q, high_coef_q;
	logic signed [SAMPLE_W-1:0] x_q, xp_q;
	logic signed [DC_W-1:0]     yp_q;
	logic signed [RW-1:0]       s1_q [NUM_BINS];
	logic signed [RW-1:0]       s2_q [NUM_BINS];
	logic signed [PW-1:0]       p_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       acc_en_s1, sub_s1, plus14_s1;
	logic [SHIFT_IDX_W-1:0]     shift_s1;
	logic [ENERGY_W-1:0]        energy_q [NUM_BINS];

	logic signed [COEF_W-1:0]    coef_sel;
	logic signed [RW-1:0]        s1_sel, s2_sel;
	logic signed [PX_W-1:0]      s1_x, s2_x, p_x;
	logic signed [OP_W-1:0]      a_op, b_op;
	logic signed [PROD_W-1:0]    product;
	logic [SHAMT_W-1:0]          shamt;
	logic signed [ACC_W-1:0]     term, acc_next;
	logic                        acc_clr;
	logic signed [DC_SUM_W-1:0]  dc_sum;
	logic signed [DC_W-1:0]      dc_y;
	logic signed [REC_SUM_W-1:0] rec_sum;
	logic signed [RW-1:0]        rec_s0;
	logic signed [EXT_W-1:0]     acc_ext;
	logic [ENERGY_W-1:0]         energy_val;

	function automatic logic signed [OP_W-1:0] chunk_op(
		input logic [PX_W-1:0]        v,
		input logic [CHUNK_IDX_W-1:0] idx,
		input logic [CHUNK_IDX_W-1:0] top
	);
		logic [CHUNK_W-1:0] c;
		c = v[idx*CHUNK_W +: CHUNK_W];
		return {(idx == top) & c[CHUNK_W-1], c};
	endfunction

	always_comb begin
		case (cmd.bin)
			BIN_LOW:  coef_sel = low_coef_q;
			BIN_HIGH: coef_sel = high_coef_q;
			default:  coef_sel = center_coef_q;
		endcase
	end

	assign s1_sel = s1_q[cmd.bin];
	assign s2_sel = s2_q[cmd.bin];
	assign s1_x = PX_W'(s1_sel);
	assign s2_x = PX_W'(s2_sel);
	assign p_x = PX_W'(p_q);

	always_comb begin
		case (cmd.a_sel)
			A_POLE:  a_op = OP_W'(DC_POLE);
			A_COEF:  a_op = OP_W'(coef_sel);
			A_S1:    a_op = chunk_op(s1_x, cmd.a_chunk, S_TOP);
			A_S2:    a_op = chunk_op(s2_x, cmd.a_chunk, S_TOP);
			A_P:     a_op = chunk_op(p_x, cmd.a_chunk, P_TOP);
			default: a_op = '0;
		endcase
	end

	always_comb begin
		case (cmd.b_sel)
			B_YP:    b_op = OP_W'(yp_q);
			B_S1:    b_op = chunk_op(s1_x, cmd.b_chunk, S_TOP);
			B_S2:    b_op = chunk_op(s2_x, cmd.b_chunk, S_TOP);
			default: b_op = '0;
		endcase
	end

	assign product = a_op * b_op;

	assign shamt = SHAMT_W'(shift_s1) * SHAMT_W'(CHUNK_W)
		+ (plus14_s1 ? SHAMT_W'(SQ_SHIFT) : SHAMT_W'(0));
	assign term = ACC_W'(prod_s1) <<< shamt;
	assign acc_next = sub_s1 ? (acc_q - term) : (acc_q + term);

	always_comb begin
		case (cmd.op) inside
			OP_DC_FIN, OP_REC_FIN, OP_P_LOAD, OP_E_FIN: acc_clr = 1'b1;
			default: acc_clr = 1'b0;
		endcase
	end

	assign dc_sum = DC_SUM_W'(x_q) - DC_SUM_W'(xp_q) + $signed(acc_q[DC_SHIFT +: DC_SUM_W]);

	always_comb begin
		if ((&dc_sum[DC_SUM_W-1:DC_W-1]) || !(|dc_sum[DC_SUM_W-1:DC_W-1])) begin
			dc_y = dc_sum[DC_W-1:0];
		end else if (dc_sum[DC_SUM_W-1]) begin
			dc_y = {1'b1, {(DC_W-1){1'b0}}};
		end else begin
			dc_y = {1'b0, {(DC_W-1){1'b1}}};
		end
	end

	assign rec_sum = REC_SUM_W'(yp_q) + $signed(acc_q[COEF_SHIFT +: REC_SUM_W])
		- REC_SUM_W'(s2_sel);

	always_comb begin
		if ((&rec_sum[REC_SUM_W-1:RW-1]) || !(|rec_sum[REC_SUM_W-1:RW-1])) begin
			rec_s0 = rec_sum[RW-1:0];
		end else if (rec_sum[REC_SUM_W-1]) begin
			rec_s0 = {1'b1, {(RW-1){1'b0}}};
		end else begin
			rec_s0 = {1'b0, {(RW-1){1'b1}}};
		end
	end

	assign acc_ext = EXT_W'(acc_q);

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			energy_val = '0;
		end else if (|acc_ext[EXT_W-1:ENERGY_SHIFT+ENERGY_W]) begin
			energy_val = '1;
		end else begin
			energy_val = acc_ext[ENERGY_SHIFT +: ENERGY_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_coef_q <= CENTER_COEF_RESET;
			low_coef_q <= LOW_COEF_RESET;
			high_coef_q <= HIGH_COEF_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_CENTER_COEF) begin
				center_coef_q <= cfg_data[COEF_W-1:0];
			end
			if (cfg_index == REG_LOW_COEF) begin
				low_coef_q <= cfg_data[COEF_W-1:0];
			end
			if (cfg_index == REG_HIGH_COEF) begin
				high_coef_q <= cfg_data[COEF_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
			sub_s1 <= 1'b0;
			plus14_s1 <= 1'b0;
			shift_s1 <= '0;
			acc_q <= '0;
		end else begin
			acc_en_s1 <= cmd.mul;
			sub_s1 <= cmd.sub;
			plus14_s1 <= cmd.plus14;
			shift_s1 <= cmd.shift;
			if (acc_en_s1) begin
				acc_q <= acc_next;
			end else if (acc_clr) begin
				acc_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= product;
		if (cmd.op == OP_TAKE) begin
			x_q <= sample;
		end
		if (cmd.op == OP_P_LOAD) begin
			p_q <= acc_q[PW-1:0];
		end
		if (cmd.op == OP_E_FIN) begin
			energy_q[cmd.bin] <= energy_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_q <= '0;
			yp_q <= '0;
			for (int b = 0; b < NUM_BINS; b++) begin
				s1_q[b] <= '0;
				s2_q[b] <= '0;
			end
		end else begin
			if (cmd.op == OP_DC_FIN) begin
				yp_q <= dc_y;
				xp_q <= x_q;
			end
			for (int b = 0; b < NUM_BINS; b++) begin
				if (cmd.clear_bins) begin
					s1_q[b] <= '0;
					s2_q[b] <= '0;
				end else if (cmd.op == OP_REC_FIN && cmd.bin == BIN_W'(b)) begin
					s1_q[b] <= rec_s0;
					s2_q[b] <= s1_q[b];
				end
			end
		end
	end

	assign status.acc_pending = acc_en_s1;
	assign center_energy = energy_q[BIN_CENTER];
	assign low_energy = energy_q[BIN_LOW];
	assign high_energy = energy_q[BIN_HIGH];

endmodule

// ===== rtl/core/dcgz_ctrl.sv =====
// Controller: handshakes, block position counter and the micro-operation sequencer.
module dcgz_ctrl #(
	parameter int MAX_BLOCK = 1024,
	parameter int RECURRENCE_WIDTH = 40
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	output logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            cfg_write,
	input  logic [dcgz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcgz_pkg::CFG_DATA_W-1:0] cfg_data,
	output dcgz_pkg::dp_cmd_t               cmd,
	input  dcgz_pkg::dp_status_t            status
);
	import dcgz_pkg::*;

	localparam int RW = RECURRENCE_WIDTH;
	localparam int PW = RW + COEF_W;
	localparam int NCS = (RW + CHUNK_W - 1) / CHUNK_W;
	localparam int NCP = (PW + CHUNK_W - 1) / CHUNK_W;
	localparam logic [CHUNK_IDX_W-1:0] S_TOP = CHUNK_IDX_W'(NCS - 1);
	localparam logic [CHUNK_IDX_W-1:0] P_TOP = CHUNK_IDX_W'(NCP - 1);
	localparam int POS_W = $clog2(MAX_BLOCK);
	localparam int LEN_W = ($clog2(MAX_BLOCK + 1) > BLOCK_LEN_W) ?
		$clog2(MAX_BLOCK + 1) : BLOCK_LEN_W;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_DC       = 12'b0000_0000_0010,
		S_DC_FIN   = 12'b0000_0000_0100,
		S_REC      = 12'b0000_0000_1000,
		S_REC_FIN  = 12'b0000_0001_0000,
		S_WAIT_OUT = 12'b0000_0010_0000,
		S_EP       = 12'b0000_0100_0000,
		S_EP_LD    = 12'b0000_1000_0000,
		S_ESQ1     = 12'b0001_0000_0000,
		S_ESQ2     = 12'b0010_0000_0000,
		S_ECR      = 12'b0100_0000_0000,
		S_EFIN     = 12'b1000_0000_0000
	} state_t;

	state_t                  state_q, state_d;
	logic [CHUNK_IDX_W-1:0]  i_q, i_d, j_q, j_d;
	logic [BIN_W-1:0]        k_q, k_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic [BLOCK_LEN_W-1:0]  block_len_q;
	logic                    out_valid_q, set_out;
	logic [LEN_W-1:0]        len_ext, eff_len;
	logic                    block_done, last_j, last_i_s, last_i_p;

	assign len_ext = LEN_W'(block_len_q);

	always_comb begin
		if (len_ext < LEN_W'(MIN_BLOCK)) begin
			eff_len = LEN_W'(MIN_BLOCK);
		end else if (len_ext > LEN_W'(MAX_BLOCK)) begin
			eff_len = LEN_W'(MAX_BLOCK);
		end else begin
			eff_len = len_ext;
		end
	end

	assign block_done = (LEN_W'(pos_q) + LEN_W'(1)) >= eff_len;
	assign last_j = (j_q == S_TOP);
	assign last_i_s = (i_q == S_TOP);
	assign last_i_p = (i_q == P_TOP);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		pos_d = pos_q;
		set_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_TAKE;
					state_d = S_DC;
				end
			end
			S_DC: begin
				cmd.mul = 1'b1;
				cmd.a_sel = A_POLE;
				cmd.b_sel = B_YP;
				state_d = S_DC_FIN;
			end
			S_DC_FIN: begin
				if (!status.acc_pending) begin
					cmd.op = OP_DC_FIN;
					k_d = BIN_CENTER;
					j_d = '0;
					state_d = S_REC;
				end
			end
			S_REC, S_EP: begin
				cmd.mul = 1'b1;
				cmd.a_sel = A_COEF;
				cmd.b_sel = B_S1;
				cmd.b_chunk = j_q;
				cmd.shift = SHIFT_IDX_W'(j_q);
				cmd.bin = k_q;
				if (last_j) begin
					j_d = '0;
					state_d = (state_q == S_REC) ? S_REC_FIN : S_EP_LD;
				end else begin
					j_d = j_q + CHUNK_IDX_W'(1);
				end
			end
			S_REC_FIN: begin
				cmd.bin = k_q;
				if (!status.acc_pending) begin
					cmd.op = OP_REC_FIN;
					if (k_q == BIN_HIGH) begin
						if (block_done) begin
							pos_d = '0;
							state_d = S_WAIT_OUT;
						end else begin
							pos_d = pos_q + POS_W'(1);
							state_d = S_IDLE;
						end
					end else begin
						k_d = k_q + BIN_W'(1);
						state_d = S_REC;
					end
				end
			end
			S_WAIT_OUT: begin
				if (!out_valid_q) begin
					k_d = BIN_CENTER;
					j_d = '0;
					state_d = S_EP;
				end
			end
			S_EP_LD: begin
				cmd.bin = k_q;
				if (!status.acc_pending) begin
					cmd.op = OP_P_LOAD;
					i_d = '0;
					j_d = '0;
					state_d = S_ESQ1;
				end
			end
			S_ESQ1, S_ESQ2: begin
				cmd.mul = 1'b1;
				cmd.a_sel = (state_q == S_ESQ1) ? A_S1 : A_S2;
				cmd.b_sel = (state_q == S_ESQ1) ? B_S1 : B_S2;
				cmd.a_chunk = i_q;
				cmd.b_chunk = j_q;
				cmd.shift = SHIFT_IDX_W'(i_q) + SHIFT_IDX_W'(j_q);
				cmd.plus14 = 1'b1;
				cmd.bin = k_q;
				if (last_j) begin
					j_d = '0;
					if (last_i_s) begin
						i_d = '0;
						state_d = (state_q == S_ESQ1) ? S_ESQ2 : S_ECR;
					end else begin
						i_d = i_q + CHUNK_IDX_W'(1);
					end
				end else begin
					j_d = j_q + CHUNK_IDX_W'(1);
				end
			end
			S_ECR: begin
				cmd.mul = 1'b1;
				cmd.a_sel = A_P;
				cmd.b_sel = B_S2;
				cmd.a_chunk = i_q;
				cmd.b_chunk = j_q;
				cmd.shift = SHIFT_IDX_W'(i_q) + SHIFT_IDX_W'(j_q);
				cmd.sub = 1'b1;
				cmd.bin = k_q;
				if (last_j) begin
					j_d = '0;
					if (last_i_p) begin
						i_d = '0;
						state_d = S_EFIN;
					end else begin
						i_d = i_q + CHUNK_IDX_W'(1);
					end
				end else begin
					j_d = j_q + CHUNK_IDX_W'(1);
				end
			end
			S_EFIN: begin
				cmd.bin = k_q;
				if (!status.acc_pending) begin
					cmd.op = OP_E_FIN;
					if (k_q == BIN_HIGH) begin
						cmd.clear_bins = 1'b1;
						set_out = 1'b1;
						state_d = S_IDLE;
					end else begin
						k_d = k_q + BIN_W'(1);
						state_d = S_EP;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
			pos_q <= pos_d;
			if (set_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q <= BLOCK_LEN_RESET;
		end else if (cfg_write && cfg_index == REG_BLOCK_LEN) begin
			block_len_q <= cfg_data[BLOCK_LEN_W-1:0];
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== sim/tb_dc_blocked_goertzel_tone_detector.sv =====
// Self-checking testbench for the DC-blocked three-bin Goertzel tone detector.
module tb_dc_blocked_goertzel_tone_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import dcgz_pkg::*;

	localparam int MAX_BLOCK_LEN = 1024;
	localparam int RECURRENCE_W = 40;
	localparam int SHORTEST_BLOCK = 8;
	localparam int BLOCKED_W = 18;
	localparam int POLE_FRAC = 15;
	localparam int COEF_FRAC = 14;
	localparam int CROSS_FRAC = 14;
	localparam int ENERGY_FRAC = 30;
	localparam logic signed [63:0] DC_POLE_Q15 = 64'sd32604;
	localparam logic signed [127:0] ENERGY_MAX = (128'sd1 <<< 63) - 128'sd1;
	localparam int RANDOM_ITEMS = 700;
	localparam int MIN_RESULTS = 40;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_OFF_CYCLES = 2000;
	localparam int MAX_GAP = 6;
	localparam int TIMEOUT_NS = 2000000;

	typedef struct packed {
		logic [ENERGY_W-1:0] center;
		logic [ENERGY_W-1:0] low;
		logic [ENERGY_W-1:0] high;
	} bin_energies_t;

	typedef enum int {
		WAVE_NOISE,
		WAVE_SQUARE,
		WAVE_NYQUIST,
		WAVE_QUIET,
		WAVE_DC
	} wave_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ENERGY_W-1:0] center_energy;
	logic [ENERGY_W-1:0] low_energy;
	logic [ENERGY_W-1:0] high_energy;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Detector state and register copy kept by the predictor.
	logic signed [COEF_W-1:0] bin_coef [3] = '{16'sd20628, 16'sd24578, 16'sd16076};
	logic [BLOCK_LEN_W-1:0] block_len = 11'd48;
	logic signed [SAMPLE_W-1:0] dc_last_in = '0;
	logic signed [BLOCKED_W-1:0] dc_last_out = '0;
	logic signed [RECURRENCE_W-1:0] bin_s1 [3] = '{'0, '0, '0};
	logic signed [RECURRENCE_W-1:0] bin_s2 [3] = '{'0, '0, '0};
	int block_pos = 0;

	logic signed [SAMPLE_W-1:0] pending_samples [$];
	bin_energies_t expected_energies [$];
	bin_energies_t oldest_energies;

	logic sample_taken = 1'b0;
	logic result_taken = 1'b0;
	int send_wait = 0;
	bit send_burst = 1'b0;
	int recv_wait = 0;
	bit recv_burst = 1'b0;
	int hold_cycles = 0;
	int mismatches = 0;
	int energy_results = 0;

	dc_blocked_goertzel_tone_detector #(
		.MAX_BLOCK(MAX_BLOCK_LEN),
		.RECURRENCE_WIDTH(RECURRENCE_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_energy(center_energy),
		.low_energy(low_energy),
		.high_energy(high_energy),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [63:0] clamp_signed(input logic signed [63:0] v, input int w);
		logic signed [63:0] top;
		top = (64'sd1 <<< (w - 1)) - 64'sd1;
		if (v > top)
			return top;
		if (v < -top - 64'sd1)
			return -top - 64'sd1;
		return v;
	endfunction

	function automatic logic [ENERGY_W-1:0] bin_energy(input logic signed [RECURRENCE_W-1:0] s1,
			input logic signed [RECURRENCE_W-1:0] s2, input logic signed [COEF_W-1:0] c);
		logic signed [127:0] a;
		logic signed [127:0] b;
		logic signed [127:0] k;
		logic signed [127:0] t;
		a = 128'(s1);
		b = 128'(s2);
		k = 128'(c);
		t = ((a * a + b * b) <<< CROSS_FRAC) - k * a * b;
		if (t < 0)
			return '0;
		t = t >>> ENERGY_FRAC;
		if (t > ENERGY_MAX)
			return {ENERGY_W{1'b1}};
		return t[ENERGY_W-1:0];
	endfunction

	function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] x);
		logic signed [63:0] xe;
		logic signed [63:0] y;
		logic signed [63:0] acc;
		bin_energies_t e;
		int len;
		int b;
		xe = 64'(x);
		acc = xe - dc_last_in + ((DC_POLE_Q15 * dc_last_out) >>> POLE_FRAC);
		y = clamp_signed(acc, BLOCKED_W);
		dc_last_in = x;
		dc_last_out = y[BLOCKED_W-1:0];
		for (b = 0; b < NUM_BINS; b++) begin
			acc = y + ((bin_coef[b] * bin_s1[b]) >>> COEF_FRAC) - bin_s2[b];
			acc = clamp_signed(acc, RECURRENCE_W);
			bin_s2[b] = bin_s1[b];
			bin_s1[b] = acc[RECURRENCE_W-1:0];
		end
		block_pos++;
		len = int'(block_len);
		if (len < SHORTEST_BLOCK)
			len = SHORTEST_BLOCK;
		else if (len > MAX_BLOCK_LEN)
			len = MAX_BLOCK_LEN;
		if (block_pos >= len) begin
			e.center = bin_energy(bin_s1[BIN_CENTER], bin_s2[BIN_CENTER], bin_coef[BIN_CENTER]);
			e.low = bin_energy(bin_s1[BIN_LOW], bin_s2[BIN_LOW], bin_coef[BIN_LOW]);
			e.high = bin_energy(bin_s1[BIN_HIGH], bin_s2[BIN_HIGH], bin_coef[BIN_HIGH]);
			expected_energies.push_back(e);
			for (b = 0; b < NUM_BINS; b++) begin
				bin_s1[b] = '0;
				bin_s2[b] = '0;
			end
			block_pos = 0;
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] wave_sample(input wave_t shape, input int n,
			input int amp, input int half);
		case (shape)
			WAVE_NOISE: return SAMPLE_W'($urandom_range(0, 65535));
			WAVE_SQUARE: return SAMPLE_W'(((n / half) % 2) ? amp : -amp);
			WAVE_NYQUIST: return (n % 2) ? 16'sh7FFF : 16'sh8000;
			WAVE_QUIET: return SAMPLE_W'($urandom_range(0, 16) - 8);
			default: return SAMPLE_W'(amp);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_coef();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return CFG_DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic report_error(input string what);
		$display("@%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		case (index)
			REG_CENTER_COEF: bin_coef[BIN_CENTER] = data;
			REG_LOW_COEF: bin_coef[BIN_LOW] = data;
			REG_HIGH_COEF: bin_coef[BIN_HIGH] = data;
			REG_BLOCK_LEN: block_len = data[BLOCK_LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic queue_wave(input wave_t shape, input int count, input int amp, input int half);
		int n;
		@(posedge clk);
		for (n = 0; n < count; n++)
			pending_samples.push_back(wave_sample(shape, n, amp, half));
	endtask

	task automatic settle();
		while (pending_samples.size() != 0 || in_valid || expected_energies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		sample_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			absorb_sample(sample);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || sample_taken) begin
			if (send_wait > 0) begin
				in_valid <= 1'b0;
				send_wait--;
			end else if (pending_samples.size() != 0) begin
				sample <= pending_samples.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					send_burst = !send_burst;
				send_wait = send_burst ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			energy_results++;
			if (expected_energies.size() == 0) begin
				report_error("energy request with no block outstanding");
			end else begin
				oldest_energies = expected_energies.pop_front();
				if (center_energy !== oldest_energies.center)
					report_error($sformatf("center energy %0d, expected %0d",
						center_energy, oldest_energies.center));
				if (low_energy !== oldest_energies.low)
					report_error($sformatf("low energy %0d, expected %0d",
						low_energy, oldest_energies.low));
				if (high_energy !== oldest_energies.high)
					report_error($sformatf("high energy %0d, expected %0d",
						high_energy, oldest_energies.high));
			end
		end
	end

	always @(negedge clk) begin
		if (result_taken) begin
			if ($urandom_range(0, 15) == 0)
				recv_burst = !recv_burst;
			recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else if (out_valid && recv_wait > 0) begin
			out_stall <= 1'b1;
			recv_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		int n_random;
		int count;
		int amp;
		wave_t shape;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Extremes at the reset settings, then a short length that closes the open block.
		@(posedge clk);
		pending_samples = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0000,
			16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFF};
		settle();
		write_reg(REG_CENTER_COEF, 16'h8000);
		write_reg(REG_LOW_COEF, 16'h7FFF);
		write_reg(REG_HIGH_COEF, 16'h0000);
		write_reg(REG_BLOCK_LEN, 16'h0003);
		queue_wave(WAVE_NYQUIST, 9, 0, 1);
		settle();

		n_random = 0;
		while (n_random < RANDOM_ITEMS || energy_results < MIN_RESULTS) begin
			if ($urandom_range(0, 1))
				write_reg(REG_CENTER_COEF, random_coef());
			if ($urandom_range(0, 1))
				write_reg(REG_LOW_COEF, random_coef());
			if ($urandom_range(0, 1))
				write_reg(REG_HIGH_COEF, random_coef());
			if ($urandom_range(0, 1))
				write_reg(REG_BLOCK_LEN, {5'($urandom_range(0, 31)), 11'($urandom_range(0, 40))});
			shape = wave_t'($urandom_range(0, 4));
			count = $urandom_range(8, 64);
			amp = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 32767);
			queue_wave(shape, count, amp, $urandom_range(1, 8));
			n_random += count;
			settle();
		end

		// Hold results back long enough for the detector to stall its sample input.
		write_reg(REG_BLOCK_LEN, 16'd8);
		queue_wave(WAVE_NOISE, 120, 0, 1);
		hold_cycles = HOLD_OFF_CYCLES;
		settle();

		write_reg(REG_BLOCK_LEN, 16'hFFFF);
		queue_wave(WAVE_NOISE, 30, 0, 1);
		settle();
		write_reg(REG_BLOCK_LEN, 16'd9);
		queue_wave(WAVE_SQUARE, 10, 32767, 2);
		settle();

		// A long block driven at Nyquist grows the recurrences far beyond the sample range.
		write_reg(REG_CENTER_COEF, 16'h8000);
		write_reg(REG_LOW_COEF, 16'h7FFF);
		write_reg(REG_HIGH_COEF, random_coef());
		write_reg(REG_BLOCK_LEN, 16'd200);
		queue_wave(WAVE_NYQUIST, 200, 0, 1);
		settle();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout waiting for the detector.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
